// File: src/tpm_pkg.sv
package tpm_pkg;

	// Default configuration of the block
	localparam int DEF_PROCESSES   = 4;
	localparam int DEF_TLB_ENTRIES = 8;
	localparam int DEF_PAGE_BITS   = 6;
	localparam int DEF_FRAME_BITS  = 8;

	// Fixed field widths
	localparam int OP_BITS    = 3;
	localparam int STAMP_BITS = 32;

	// Operation codes; the remaining codes are no-ops
	typedef enum logic [OP_BITS-1:0] {
		OP_SWITCH    = 3'd0,
		OP_MAP       = 3'd1,
		OP_UNMAP     = 3'd2,
		OP_READ_PAGE = 3'd3,
		OP_READ_TLB  = 3'd4
	} op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_EXEC
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic scan_step;
		logic exec;
	} tpm_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clear_last;
		logic scan_last;
		logic in_scan;
	} tpm_stat_t;

endpackage

// File: src/tlb_page_table_manager.sv
// Page table and process-tagged TLB with oldest-stamp replacement. One request
// goes in on the slave stream and exactly one result comes out on the master
// stream, in order. Switch, both reads and the no-op codes pass through the
// accepting cycle and the commit cycle, and their result is registered in the
// output register at commit. Map and unmap insert a slot search between the
// two, which walks the TLB one slot per cycle through a single compare unit,
// and their result is likewise registered at commit. The page table sits in a
// single-port-write memory of PROCESSES * 2**PAGE_BITS entries (256 at the
// default size), which is swept to zero after reset before the first request
// is taken. A result waiting in the output register does not block the next
// request from being accepted; that request then holds in its commit cycle,
// with the input closed, until the master side takes the waiting result.
module tlb_page_table_manager import tpm_pkg::*; #(
	parameter int PROCESSES   = DEF_PROCESSES,
	parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
	parameter int PAGE_BITS   = DEF_PAGE_BITS,
	parameter int FRAME_BITS  = DEF_FRAME_BITS,
	localparam int PROC_BITS  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1,
	localparam int PID_BITS   = $clog2(PROCESSES + 1),
	localparam int SLOT_BITS  = $clog2(TLB_ENTRIES),
	localparam int IN_BITS    = OP_BITS + PAGE_BITS + FRAME_BITS + PID_BITS + SLOT_BITS,
	localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS   = 2 + 2 * PROC_BITS + SLOT_BITS + PAGE_BITS + FRAME_BITS
		+ STAMP_BITS,
	localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// operation, virtual_page, frame_number, process_id, tlb_slot
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// status, active_process, slot_used, entry_page, entry_frame,
	// entry_valid, entry_owner, entry_stamp
	output logic [OUT_W-1:0] m_tdata
);

	tpm_cmd_t  cmd;
	tpm_stat_t st;

	tpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tpm_datapath #(
		.PROCESSES   (PROCESSES),
		.TLB_ENTRIES (TLB_ENTRIES),
		.PAGE_BITS   (PAGE_BITS),
		.FRAME_BITS  (FRAME_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.st      (st)
	);

endmodule

// File: src/tpm_ctrl.sv
module tpm_ctrl import tpm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  tpm_stat_t st,
	output tpm_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   m_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (st.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = st.in_scan ? ST_SCAN : ST_EXEC;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// Commit only once the output register is free
				if (!m_valid_q || m_tready) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the result until the master side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;

endmodule

// File: src/tpm_datapath.sv
module tpm_datapath import tpm_pkg::*; #(
	parameter int PROCESSES   = DEF_PROCESSES,
	parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
	parameter int PAGE_BITS   = DEF_PAGE_BITS,
	parameter int FRAME_BITS  = DEF_FRAME_BITS,
	localparam int PROC_BITS  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1,
	localparam int PID_BITS   = $clog2(PROCESSES + 1),
	localparam int SLOT_BITS  = $clog2(TLB_ENTRIES),
	localparam int IN_BITS    = OP_BITS + PAGE_BITS + FRAME_BITS + PID_BITS + SLOT_BITS,
	localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS   = 2 + 2 * PROC_BITS + SLOT_BITS + PAGE_BITS + FRAME_BITS
		+ STAMP_BITS,
	localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  s_tdata,
	output logic [OUT_W-1:0] m_tdata,
	input  tpm_cmd_t         cmd,
	output tpm_stat_t        st
);

	localparam int MEM_DEPTH  = PROCESSES << PAGE_BITS;
	localparam int ADDR_BITS  = $clog2(MEM_DEPTH);
	localparam int IDX_BITS   = PROC_BITS + PAGE_BITS;
	localparam int VPN_LO     = OP_BITS;
	localparam int PFN_LO     = VPN_LO + PAGE_BITS;
	localparam int PID_LO     = PFN_LO + FRAME_BITS;
	localparam int SLOT_LO    = PID_LO + PID_BITS;

	// Incoming request fields
	logic [OP_BITS-1:0]    in_op;
	logic [PAGE_BITS-1:0]  in_vpn;
	logic [FRAME_BITS-1:0] in_pfn;
	logic [PID_BITS-1:0]   in_pid;
	logic [SLOT_BITS-1:0]  in_slot;

	assign in_op   = s_tdata[OP_BITS-1:0];
	assign in_vpn  = s_tdata[VPN_LO +: PAGE_BITS];
	assign in_pfn  = s_tdata[PFN_LO +: FRAME_BITS];
	assign in_pid  = s_tdata[PID_LO +: PID_BITS];
	assign in_slot = s_tdata[SLOT_LO +: SLOT_BITS];

	// Request registers
	logic [OP_BITS-1:0]    op_q;
	logic [PAGE_BITS-1:0]  vpn_q;
	logic [FRAME_BITS-1:0] pfn_q;
	logic [PID_BITS-1:0]   pid_q;
	logic [SLOT_BITS-1:0]  slot_q;

	// Architectural state
	logic [PROC_BITS-1:0]  cur_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [ADDR_BITS-1:0]  clr_idx_q;

	logic [PAGE_BITS-1:0]  tlb_page_q  [TLB_ENTRIES];
	logic [FRAME_BITS-1:0] tlb_frame_q [TLB_ENTRIES];
	logic                  tlb_valid_q [TLB_ENTRIES];
	logic [PROC_BITS-1:0]  tlb_owner_q [TLB_ENTRIES];
	logic [STAMP_BITS-1:0] tlb_stamp_q [TLB_ENTRIES];

	// Page table memory: {frame, valid}
	logic [FRAME_BITS:0]   mem [MEM_DEPTH];
	logic [FRAME_BITS:0]   rd_q;
	logic [FRAME_BITS:0]   mem_wd;
	logic                  mem_we;
	logic [ADDR_BITS-1:0]  rd_addr;
	logic [ADDR_BITS-1:0]  wr_addr;
	logic [IDX_BITS-1:0]   rd_idx;
	logic [IDX_BITS-1:0]   wr_idx;

	// Slot scan trackers
	logic [SLOT_BITS-1:0]  scan_idx_q;
	logic                  hit_found_q;
	logic [SLOT_BITS-1:0]  hit_idx_q;
	logic                  free_found_q;
	logic [SLOT_BITS-1:0]  free_idx_q;
	logic [SLOT_BITS-1:0]  best_idx_q;
	logic [STAMP_BITS-1:0] best_stamp_q;

	// Slot under the scan index
	logic [PAGE_BITS-1:0]  sel_page;
	logic [FRAME_BITS-1:0] sel_frame;
	logic                  sel_valid;
	logic [PROC_BITS-1:0]  sel_owner;
	logic [STAMP_BITS-1:0] sel_stamp;
	logic                  sel_hit;
	logic                  sel_in_range;

	logic [SLOT_BITS-1:0]  chosen;
	logic                  pid_ok;

	// Result fields
	logic                  res_status;
	logic [PROC_BITS-1:0]  res_active;
	logic [SLOT_BITS-1:0]  res_slot;
	logic [PAGE_BITS-1:0]  res_page;
	logic [FRAME_BITS-1:0] res_frame;
	logic                  res_valid;
	logic [PROC_BITS-1:0]  res_owner;
	logic [STAMP_BITS-1:0] res_stamp;
	logic [OUT_W-1:0]      out_q;

	// Status towards the controller
	assign st.clear_last = (clr_idx_q == ADDR_BITS'(MEM_DEPTH - 1));
	assign st.scan_last  = (scan_idx_q == SLOT_BITS'(TLB_ENTRIES - 1));
	assign st.in_scan    = (in_op == OP_MAP) || (in_op == OP_UNMAP);

	// Capture the request, advance the stamp
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= in_op;
			vpn_q  <= in_vpn;
			pfn_q  <= in_pfn;
			pid_q  <= in_pid;
			slot_q <= in_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q <= STAMP_BITS'(1);
		end else if (cmd.accept) begin
			stamp_q <= stamp_q + STAMP_BITS'(1);
		end
	end

	// Sweep the page table after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clear_wr && !st.clear_last) begin
			clr_idx_q <= clr_idx_q + ADDR_BITS'(1);
		end
	end

	// Page table addressing
	assign rd_idx  = {cur_q, in_vpn};
	assign wr_idx  = {cur_q, vpn_q};
	assign rd_addr = rd_idx[ADDR_BITS-1:0];

	always_comb begin
		mem_we  = 1'b0;
		mem_wd  = '0;
		wr_addr = wr_idx[ADDR_BITS-1:0];
		if (cmd.clear_wr) begin
			mem_we  = 1'b1;
			wr_addr = clr_idx_q;
		end else if (cmd.exec && (op_q == OP_MAP)) begin
			mem_we = 1'b1;
			mem_wd = {pfn_q, 1'b1};
		end else if (cmd.exec && (op_q == OP_UNMAP)) begin
			mem_we = 1'b1;
			mem_wd = {rd_q[FRAME_BITS:1], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= mem_wd;
		end
		if (cmd.accept) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Slot under the scan index
	assign sel_page     = tlb_page_q[scan_idx_q];
	assign sel_frame    = tlb_frame_q[scan_idx_q];
	assign sel_valid    = tlb_valid_q[scan_idx_q];
	assign sel_owner    = tlb_owner_q[scan_idx_q];
	assign sel_stamp    = tlb_stamp_q[scan_idx_q];
	assign sel_hit      = sel_valid && (sel_owner == cur_q) && (sel_page == vpn_q);
	assign sel_in_range = ({1'b0, scan_idx_q} < (SLOT_BITS + 1)'(TLB_ENTRIES));

	// Walk the slots: first hit, first free, oldest stamp
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			scan_idx_q   <= st.in_scan ? '0 : in_slot;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (!st.scan_last) begin
				scan_idx_q <= scan_idx_q + SLOT_BITS'(1);
			end
			if (sel_hit && !hit_found_q) begin
				hit_found_q <= 1'b1;
				hit_idx_q   <= scan_idx_q;
			end
			if (!sel_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= scan_idx_q;
			end
			if ((scan_idx_q == '0) || (sel_stamp < best_stamp_q)) begin
				best_idx_q   <= scan_idx_q;
				best_stamp_q <= sel_stamp;
			end
		end
	end

	assign chosen = hit_found_q ? hit_idx_q : (free_found_q ? free_idx_q : best_idx_q);
	assign pid_ok = (pid_q < PID_BITS'(PROCESSES));

	// Commit the request to the process register and the TLB
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				tlb_page_q[i]  <= '0;
				tlb_frame_q[i] <= '0;
				tlb_valid_q[i] <= 1'b0;
				tlb_owner_q[i] <= '0;
				tlb_stamp_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			if ((op_q == OP_SWITCH) && pid_ok) begin
				cur_q <= pid_q[PROC_BITS-1:0];
			end
			if (op_q == OP_MAP) begin
				tlb_page_q[chosen]  <= vpn_q;
				tlb_frame_q[chosen] <= pfn_q;
				tlb_valid_q[chosen] <= 1'b1;
				tlb_owner_q[chosen] <= cur_q;
				tlb_stamp_q[chosen] <= stamp_q;
			end
			if ((op_q == OP_UNMAP) && hit_found_q) begin
				tlb_valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	// Build the result
	always_comb begin
		res_status = 1'b0;
		res_active = cur_q;
		res_slot   = '0;
		res_page   = '0;
		res_frame  = '0;
		res_valid  = 1'b0;
		res_owner  = '0;
		res_stamp  = '0;
		unique case (op_q)
			OP_SWITCH: begin
				if (pid_ok) begin
					res_active = pid_q[PROC_BITS-1:0];
				end else begin
					res_status = 1'b1;
				end
			end
			OP_MAP: begin
				res_slot = chosen;
			end
			OP_READ_PAGE: begin
				res_frame = rd_q[FRAME_BITS:1];
				res_valid = rd_q[0];
			end
			OP_READ_TLB: begin
				res_slot = slot_q;
				if (sel_in_range) begin
					res_page  = sel_page;
					res_frame = sel_frame;
					res_valid = sel_valid;
					res_owner = sel_owner;
					res_stamp = sel_stamp;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_q <= OUT_W'({res_stamp, res_owner, res_valid, res_frame, res_page,
				res_slot, res_active, res_status});
		end
	end

	assign m_tdata = out_q;

endmodule
